@@ rtl/oltbl_pkg.sv @@
// ----------------------------------------------------------------------------
// oltbl_pkg
// Shared types and constants of the ordered list table engine: command and
// status codes, request and response items, list depth and index widths.
// ----------------------------------------------------------------------------
`default_nettype none

package oltbl_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int LEN_W = $clog2(DEPTH + 1);

	// field widths of the result item
	localparam int POS_W = 6;
	localparam int LESS_W = 7;
	localparam int LENGTH_W = 7;

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_SORT = 3'd1,
		CMD_REMOVE   = 3'd2,
		CMD_SEARCH   = 3'd3,
		CMD_COUNT_LT = 3'd4,
		CMD_SUM      = 3'd5,
		CMD_CLEAR    = 3'd6,
		CMD_NOP      = 3'd7
	} command_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef struct packed {
		logic        [2:0]  command;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic        [1:0]          status;
		logic        [POS_W-1:0]    position;
		logic        [LESS_W-1:0]   less_count;
		logic signed [31:0]         total;
		logic        [LENGTH_W-1:0] length;
	} rsp_item_t;

endpackage

`default_nettype wire

@@ rtl/ordered_list_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_table_engine_unit
// Bounded sorted/ordered list of signed 32-bit values in one synchronous RAM.
// Searching and updating commands walk the stored entries; every command gives one response item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid, cmd_stall | req_item_t (command, value)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_item_t (status .. length)
//
//  a walking command reads one RAM entry per cycle over the list length
//  full inserts, clear, no-op and non-inserts on an empty list skip the walk
//  reset clears the length and the control state; the RAM holds no reset value
//  cmd_stall is high while a command is in flight; a finished response
//  waits in its output register, so the next command can be taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_table_engine_unit (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_stall,
	input  oltbl_pkg::req_item_t  cmd,
	output logic                  rsp_valid,
	input  wire                   rsp_stall,
	output oltbl_pkg::rsp_item_t  rsp
);
	import oltbl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	state_t                 state_q;
	command_t               cmd_q;
	logic signed [31:0]     val_q;
	logic [LEN_W-1:0]       len_q;
	logic [IDX_W-1:0]       iss_q;
	logic [IDX_W-1:0]       last_q;
	logic                   iss_act_q;
	logic                   hit_q;
	logic                   full_q;
	logic [IDX_W-1:0]       pos_q;
	logic [LEN_W-1:0]       cnt_q;
	logic signed [31:0]     acc_q;
	logic [31:0]            carry_q;
	logic                   rsp_valid_q;
	rsp_item_t              rsp_q;

	logic                   v_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [31:0]            rdata_s1;

	logic [31:0]            mem [DEPTH];

	logic                   we;
	logic [IDX_W-1:0]       wa;
	logic [31:0]            wd;

	command_t               in_cmd;
	logic                   in_ins;
	logic                   is_ins;
	logic                   lt_s1;
	logic                   place_s1;
	logic                   cmd_xfer;
	logic                   rsp_load;
	logic [LEN_W-1:0]       new_len;
	rsp_item_t              result;

	assign in_cmd   = command_t'(cmd.command);
	assign in_ins   = (in_cmd == CMD_INS_HEAD) || (in_cmd == CMD_INS_SORT);
	assign is_ins   = (cmd_q == CMD_INS_HEAD) || (cmd_q == CMD_INS_SORT);
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_xfer = cmd_valid && !cmd_stall;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign lt_s1 = $signed(rdata_s1) < val_q;
	// a head insert goes at entry 0; a sorted one in front of the first entry not below it, or at the tail
	assign place_s1 = (cmd_q == CMD_INS_HEAD) || (LEN_W'(idx_s1) == len_q) || !lt_s1;

	// ram: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_s1 <= mem[iss_q];
	end

	always_comb begin
		we = 1'b0;
		wa = idx_s1;
		wd = carry_q;
		if (state_q == S_WALK && v_s1) begin
			case (cmd_q)
				CMD_INS_HEAD, CMD_INS_SORT: begin
					if (hit_q) begin
						we = 1'b1;
					end else if (place_s1) begin
						we = 1'b1;
						wd = val_q;
					end
				end
				CMD_REMOVE: begin
					// close the gap behind the removed entry
					if (hit_q) begin
						we = 1'b1;
						wa = idx_s1 - IDX_W'(1);
						wd = rdata_s1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		new_len = len_q;
		if (is_ins && !full_q) begin
			new_len = len_q + LEN_W'(1);
		end else if (cmd_q == CMD_REMOVE && hit_q) begin
			new_len = len_q - LEN_W'(1);
		end else if (cmd_q == CMD_CLEAR) begin
			new_len = '0;
		end

		result.status = ST_OK;
		if (full_q) begin
			result.status = ST_FULL;
		end else if ((cmd_q == CMD_REMOVE || cmd_q == CMD_SEARCH) && !hit_q) begin
			result.status = ST_MISS;
		end
		result.position   = POS_W'(pos_q);
		result.less_count = LESS_W'(cnt_q);
		result.total      = acc_q;
		result.length     = LENGTH_W'(new_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			iss_act_q   <= 1'b0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
			cmd_q       <= CMD_NOP;
		end else begin
			v_s1   <= iss_act_q;
			idx_s1 <= iss_q;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						cmd_q   <= in_cmd;
						val_q   <= cmd.value;
						hit_q   <= 1'b0;
						pos_q   <= '0;
						cnt_q   <= '0;
						acc_q   <= '0;
						iss_q   <= '0;
						full_q  <= in_ins && (len_q == LEN_W'(DEPTH));
						last_q  <= in_ins ? IDX_W'(len_q) : IDX_W'(len_q - LEN_W'(1));
						if ((in_ins && len_q == LEN_W'(DEPTH)) || in_cmd == CMD_CLEAR ||
						    in_cmd == CMD_NOP || (!in_ins && len_q == '0)) begin
							state_q <= S_DONE;
						end else begin
							iss_act_q <= 1'b1;
							state_q   <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (iss_act_q) begin
						if (iss_q == last_q) begin
							iss_act_q <= 1'b0;
						end else begin
							iss_q <= iss_q + IDX_W'(1);
						end
					end
					if (v_s1) begin
						case (cmd_q)
							CMD_INS_HEAD, CMD_INS_SORT: begin
								if (!hit_q && place_s1) begin
									hit_q   <= 1'b1;
									pos_q   <= idx_s1;
									carry_q <= rdata_s1;
								end else if (hit_q) begin
									carry_q <= rdata_s1;
								end
							end
							CMD_REMOVE, CMD_SEARCH: begin
								if (!hit_q && $signed(rdata_s1) == val_q) begin
									hit_q <= 1'b1;
									pos_q <= idx_s1;
								end
							end
							CMD_COUNT_LT: begin
								if (lt_s1) begin
									cnt_q <= cnt_q + LEN_W'(1);
								end
							end
							CMD_SUM: begin
								acc_q <= acc_q + $signed(rdata_s1);
							end
							default: ;
						endcase
						if (idx_s1 == last_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q   <= result;
						len_q   <= new_len;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(DEPTH))
		else $error("list length above depth");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_WALK))
		else $error("ram write outside a walk");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == S_WALK))
		else $error("read data returned outside a walk");

	a_full_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> !full_q)
		else $error("walk started on a refused insert");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |=> (len_q == $past(len_q)))
		else $error("length changed during a walk");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ordered list table engine with directed and random commands
// under changing idle and stall patterns, tracks the list contents in a
// shadow copy and checks every response field against the prediction.
// ----------------------------------------------------------------------------

module testbench;

	import oltbl_pkg::*;

	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_CYCLES  = 320;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
	localparam int CYCLE_LIMIT  = 1500000;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	// shadow of the list contents and the queue of predicted responses
	class sorted_list_tracker;
		logic signed [31:0] shadow_entries [DEPTH];
		int                 shadow_len;
		rsp_item_t          pending_results [$];
		int                 errors;
		int                 checked;
		int                 refusals;
		int                 misses;
		int                 peak_len;
		int                 cmd_seen [8];

		function new();
			shadow_len = 0;
			errors = 0;
			checked = 0;
			refusals = 0;
			misses = 0;
			peak_len = 0;
			foreach (cmd_seen[i])
				cmd_seen[i] = 0;
		endfunction

		function int find_equal(logic signed [31:0] v);
			for (int i = 0; i < shadow_len; i++)
				if (shadow_entries[i] == v)
					return i;
			return -1;
		endfunction

		function void insert_at(int pos, logic signed [31:0] v);
			for (int i = shadow_len; i > pos; i--)
				shadow_entries[i] = shadow_entries[i - 1];
			shadow_entries[pos] = v;
			shadow_len++;
		endfunction

		function void note_command(req_item_t item);
			rsp_item_t          r;
			int                 pos;
			int                 cnt;
			logic signed [31:0] sum;
			r = '0;
			pos = 0;
			cnt = 0;
			sum = '0;
			cmd_seen[item.command]++;
			case (command_t'(item.command))
				CMD_INS_HEAD: begin
					if (shadow_len >= DEPTH) begin
						r.status = ST_FULL;
						refusals++;
					end else begin
						insert_at(0, item.value);
					end
				end
				CMD_INS_SORT: begin
					if (shadow_len >= DEPTH) begin
						r.status = ST_FULL;
						refusals++;
					end else begin
						// goes before the first entry not less than the value
						while (pos < shadow_len && shadow_entries[pos] < item.value)
							pos++;
						r.position = POS_W'(pos);
						insert_at(pos, item.value);
					end
				end
				CMD_REMOVE: begin
					pos = find_equal(item.value);
					if (pos < 0) begin
						r.status = ST_MISS;
						misses++;
					end else begin
						for (int i = pos; i + 1 < shadow_len; i++)
							shadow_entries[i] = shadow_entries[i + 1];
						shadow_len--;
						r.position = POS_W'(pos);
					end
				end
				CMD_SEARCH: begin
					pos = find_equal(item.value);
					if (pos < 0) begin
						r.status = ST_MISS;
						misses++;
					end else begin
						r.position = POS_W'(pos);
					end
				end
				CMD_COUNT_LT: begin
					for (int i = 0; i < shadow_len; i++)
						if (shadow_entries[i] < item.value)
							cnt++;
					r.less_count = LESS_W'(cnt);
				end
				CMD_SUM: begin
					for (int i = 0; i < shadow_len; i++)
						sum = sum + shadow_entries[i];
					r.total = sum;
				end
				CMD_CLEAR: shadow_len = 0;
				default: ;
			endcase
			r.length = LENGTH_W'(shadow_len);
			if (shadow_len > peak_len)
				peak_len = shadow_len;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (pending_results.size() == 0) begin
				$error("response transfer with no command outstanding");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			compare_field("status", want.status, got.status);
			compare_field("position", want.position, got.position);
			compare_field("less_count", want.less_count, got.less_count);
			compare_field("total", want.total, got.total);
			compare_field("length", want.length, got.length);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	req_item_t cmd_item = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;

	sorted_list_tracker board = new();

	int cycle_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;

	ordered_list_table_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_item)
	);

	always #6 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d responses outstanding",
			cycle_count, board.pending());
		$display("== FAIL ==");
		$finish;
	end

	// response side: random stall, or a long hold-off when one is requested
	initial begin : receiver
		int remaining;
		int served;
		remaining = 0;
		served = 0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				remaining = HOLD_CYCLES;
			end
			if (remaining > 0) begin
				remaining--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_response(rsp_item);

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_command(command_t op, logic signed [31:0] v);
		req_item_t item;
		item.command = op;
		item.value = v;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_item <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		board.note_command(item);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] random_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			return $signed($urandom_range(16)) - 8;
		if (pick < 55 && board.shadow_len > 0)
			return board.shadow_entries[$urandom_range(board.shadow_len - 1)];
		if (pick < 65) begin
			case ($urandom_range(6))
				0: return INT_MIN;
				1: return INT_MAX;
				2: return INT_MIN + 1;
				3: return INT_MAX - 1;
				4: return -1;
				5: return 1;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic command_t random_command();
		int pick;
		pick = $urandom_range(99);
		if (pick < 22) return CMD_INS_HEAD;
		if (pick < 44) return CMD_INS_SORT;
		if (pick < 60) return CMD_REMOVE;
		if (pick < 74) return CMD_SEARCH;
		if (pick < 84) return CMD_COUNT_LT;
		if (pick < 93) return CMD_SUM;
		if (pick < 96) return CMD_CLEAR;
		return CMD_NOP;
	endfunction

	task automatic send_insert();
		send_command($urandom_range(1) ? CMD_INS_SORT : CMD_INS_HEAD, random_value());
	endtask

	// mostly mixed bursts, with fill-to-full runs and the odd clear
	task automatic run_random(int count);
		int stop_at;
		int pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(9);
			if (pick < 2) begin
				while (board.shadow_len < DEPTH)
					send_insert();
				repeat (2)
					send_insert();
				send_command(CMD_SUM, $urandom);
				send_command(CMD_COUNT_LT, random_value());
				repeat (4)
					send_command($urandom_range(1) ? CMD_SEARCH : CMD_REMOVE,
						random_value());
			end else if (pick == 2) begin
				send_command(CMD_CLEAR, $urandom);
			end else begin
				repeat ($urandom_range(30, 10))
					send_command(random_command(), random_value());
			end
		end
	endtask

	initial begin : main
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list corners, duplicates, extremes, wrap of the sum
		send_command(CMD_REMOVE, 5);
		send_command(CMD_SEARCH, 0);
		send_command(CMD_COUNT_LT, 0);
		send_command(CMD_SUM, 0);
		send_command(CMD_INS_SORT, 0);
		send_command(CMD_INS_HEAD, INT_MAX);
		send_command(CMD_INS_SORT, INT_MIN);
		send_command(CMD_INS_SORT, 0);
		send_command(CMD_INS_HEAD, -1);
		send_command(CMD_INS_SORT, INT_MAX);
		send_command(CMD_SEARCH, 0);
		send_command(CMD_SEARCH, INT_MAX);
		send_command(CMD_SEARCH, 12345);
		send_command(CMD_COUNT_LT, INT_MIN);
		send_command(CMD_COUNT_LT, INT_MAX);
		send_command(CMD_COUNT_LT, 0);
		send_command(CMD_SUM, -1);
		send_command(CMD_REMOVE, INT_MIN);
		send_command(CMD_REMOVE, 0);
		send_command(CMD_REMOVE, 777);
		send_command(CMD_NOP, -1);
		send_command(CMD_SUM, INT_MAX);
		send_command(CMD_CLEAR, INT_MIN);
		send_command(CMD_SUM, 0);
		send_command(CMD_REMOVE, 0);

		// no idling, with a long receiver hold-off while commands keep coming
		send_idle_pct = 0;
		stall_pct = 0;
		run_random(RANDOM_ITEMS / 8);
		hold_requests++;
		run_random(RANDOM_ITEMS / 8);

		send_idle_pct = 64;
		stall_pct = 0;
		run_random(RANDOM_ITEMS / 4);

		send_idle_pct = 0;
		stall_pct = 64;
		run_random(RANDOM_ITEMS / 4);

		send_idle_pct = 16;
		stall_pct = 16;
		run_random(RANDOM_ITEMS / 8);
		send_idle_pct = 0;
		hold_requests++;
		run_random(RANDOM_ITEMS / 8);

		cmd_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands sent, %0d responses checked, peak length %0d, %0d cycles",
			items_sent, board.checked, board.peak_len, cycle_count);
		$display("mix: head %0d sort %0d rm %0d find %0d cnt %0d sum %0d clr %0d nop %0d, %0d full, %0d miss",
			board.cmd_seen[CMD_INS_HEAD], board.cmd_seen[CMD_INS_SORT],
			board.cmd_seen[CMD_REMOVE], board.cmd_seen[CMD_SEARCH],
			board.cmd_seen[CMD_COUNT_LT], board.cmd_seen[CMD_SUM],
			board.cmd_seen[CMD_CLEAR], board.cmd_seen[CMD_NOP],
			board.refusals, board.misses);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/oltbl_pkg.sv
rtl/ordered_list_table_engine_unit.sv
sim/testbench.sv
